>>> design/oba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oba_pkg
// Shared constants, types and register codes of the octree block adjacency
// pipeline.
// ----------------------------------------------------------------------------
package oba_pkg;

    localparam int TREE_BITS  = 20;
    localparam int ROOT_BITS  = 10;
    localparam int COORD_W    = TREE_BITS + ROOT_BITS;
    localparam int LEVEL_W    = 5;
    localparam int LM_W       = $clog2(TREE_BITS + 1);
    // A right end can exceed the packed coordinate range by one tree block.
    localparam int LINE_W     = COORD_W + 1;
    // Root index of a right end, which can be one past the largest index.
    localparam int HI_W       = ROOT_BITS + 1;
    localparam int PERIOD_W   = 11;
    localparam int RANK_W     = 2;
    localparam int NUM_AXES   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int EQ_W       = (PERIOD_W > HI_W) ? PERIOD_W : HI_W;

    // One remainder bit per stage, plus interval, flag and output stages.
    localparam int MOD_STEPS  = HI_W;
    localparam int NUM_STAGES = MOD_STEPS + 3;

    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [LEVEL_W-1:0]     level_t;
    typedef logic [LM_W-1:0]        lm_t;
    typedef logic [LINE_W-1:0]      line_t;
    typedef logic [ROOT_BITS-1:0]   arr_t;
    typedef logic [HI_W-1:0]        hi_t;
    typedef logic [PERIOD_W-1:0]    period_t;
    typedef logic [EQ_W-1:0]        eq_t;
    typedef logic [RANK_W-1:0]      rank_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_RANK     = 2'd0;
    localparam cfg_index_t REG_PERIOD_X = 2'd1;
    localparam cfg_index_t REG_PERIOD_Y = 2'd2;
    localparam cfg_index_t REG_PERIOD_Z = 2'd3;

    localparam rank_t RANK_RESET = 2'd3;

    // Load strobes, one per pipeline stage.
    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // Alignment of both blocks to the finer level.
    typedef struct packed {
        lm_t lm;
        lm_t da;
        lm_t db;
    } level_info_t;

    // What one axis found about the pair.
    typedef struct packed {
        logic nest;
        logic apart;
    } lane_res_t;

endpackage
`default_nettype wire

>>> design/oba_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oba_lane
// One axis of the adjacency test: interval alignment, nesting and touching
// checks, and a pipelined remainder for the periodic wrap.
// ----------------------------------------------------------------------------
module oba_lane (
    input  logic                 clk,
    input  oba_pkg::stage_en_t   en,
    input  oba_pkg::level_info_t lvl,
    input  oba_pkg::lm_t         lm_s0,
    input  oba_pkg::coord_t      a_coord,
    input  oba_pkg::coord_t      b_coord,
    input  oba_pkg::period_t     period,
    output oba_pkg::lane_res_t   res
);

    typedef struct packed {
        logic             nest;
        logic             touch;
        logic             eqlo1;
        logic             eqlo2;
        oba_pkg::arr_t    arr1;
        oba_pkg::arr_t    arr2;
        oba_pkg::hi_t     x1;
        oba_pkg::hi_t     x2;
        oba_pkg::period_t rem1;
        oba_pkg::period_t rem2;
    } mod_state_t;

    function automatic oba_pkg::line_t left_at(input oba_pkg::coord_t packed_c,
                                               input oba_pkg::lm_t lm);
        oba_pkg::line_t                   arr_part;
        logic [oba_pkg::TREE_BITS-1:0]    tree_part;
        oba_pkg::lm_t                     down;
        down      = oba_pkg::lm_t'(oba_pkg::TREE_BITS) - lm;
        arr_part  = oba_pkg::line_t'(packed_c[oba_pkg::COORD_W-1:oba_pkg::TREE_BITS]) << lm;
        tree_part = packed_c[oba_pkg::TREE_BITS-1:0] >> down;
        return arr_part + oba_pkg::line_t'(tree_part);
    endfunction

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic oba_pkg::period_t mod_step(input oba_pkg::period_t rem,
                                                  input logic bit_in,
                                                  input oba_pkg::period_t per);
        logic [oba_pkg::PERIOD_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, per})
        begin
            trial = trial - {1'b0, per};
        end
        return trial[oba_pkg::PERIOD_W-1:0];
    endfunction

    oba_pkg::line_t l1_reg, l2_reg, r1_reg, r2_reg;
    oba_pkg::line_t l1_next, l2_next, r1_next, r2_next;
    oba_pkg::line_t lo_mask;

    mod_state_t stg_reg  [oba_pkg::MOD_STEPS+1];
    mod_state_t stg_next [oba_pkg::MOD_STEPS+1];

    logic wrap1, wrap2, touch_all;

    // Interval ends at the finer level.
    always_comb
    begin
        l1_next = left_at(a_coord, lvl.lm);
        l2_next = left_at(b_coord, lvl.lm);
        r1_next = l1_next + (oba_pkg::line_t'(1) << lvl.da);
        r2_next = l2_next + (oba_pkg::line_t'(1) << lvl.db);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            l1_reg <= l1_next;
            l2_reg <= l2_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    // A wrapped right end is (root part mod period) above the level bits with
    // the level bits unchanged, so the wrap test splits into a root compare
    // after the remainder and a compare of the low bits here.
    always_comb
    begin
        lo_mask = (oba_pkg::line_t'(1) << lm_s0) - oba_pkg::line_t'(1);
        stg_next[0].nest  = ((l1_reg <= l2_reg) && (r2_reg <= r1_reg)) ||
                            ((l2_reg <= l1_reg) && (r1_reg <= r2_reg));
        stg_next[0].touch = (r1_reg == l2_reg) || (l1_reg == r2_reg);
        stg_next[0].eqlo1 = (r1_reg & lo_mask) == (l2_reg & lo_mask);
        stg_next[0].eqlo2 = (l1_reg & lo_mask) == (r2_reg & lo_mask);
        stg_next[0].arr1  = oba_pkg::arr_t'(l1_reg >> lm_s0);
        stg_next[0].arr2  = oba_pkg::arr_t'(l2_reg >> lm_s0);
        stg_next[0].x1    = oba_pkg::hi_t'(r1_reg >> lm_s0);
        stg_next[0].x2    = oba_pkg::hi_t'(r2_reg >> lm_s0);
        stg_next[0].rem1  = '0;
        stg_next[0].rem2  = '0;
    end

    genvar k;
    generate
        for (k = 1; k <= oba_pkg::MOD_STEPS; k++)
        begin : g_mod
            always_comb
            begin
                stg_next[k]      = stg_reg[k-1];
                stg_next[k].rem1 = mod_step(stg_reg[k-1].rem1,
                                            stg_reg[k-1].x1[oba_pkg::HI_W-k], period);
                stg_next[k].rem2 = mod_step(stg_reg[k-1].rem2,
                                            stg_reg[k-1].x2[oba_pkg::HI_W-k], period);
            end
        end

        for (k = 0; k <= oba_pkg::MOD_STEPS; k++)
        begin : g_stg
            always_ff @(posedge clk)
            begin
                if (en[k+1])
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        wrap1 = stg_reg[oba_pkg::MOD_STEPS].eqlo1 &&
                (oba_pkg::eq_t'(stg_reg[oba_pkg::MOD_STEPS].rem1) ==
                 oba_pkg::eq_t'(stg_reg[oba_pkg::MOD_STEPS].arr2));
        wrap2 = stg_reg[oba_pkg::MOD_STEPS].eqlo2 &&
                (oba_pkg::eq_t'(stg_reg[oba_pkg::MOD_STEPS].arr1) ==
                 oba_pkg::eq_t'(stg_reg[oba_pkg::MOD_STEPS].rem2));
        touch_all = stg_reg[oba_pkg::MOD_STEPS].touch ||
                    ((period != '0) && (wrap1 || wrap2));
        res.nest  = stg_reg[oba_pkg::MOD_STEPS].nest;
        res.apart = !stg_reg[oba_pkg::MOD_STEPS].nest && !touch_all;
    end

endmodule
`default_nettype wire

>>> design/oba_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oba_merge
// Combines the per-axis findings of the active axes into the result and
// holds it in the output register.
// ----------------------------------------------------------------------------
module oba_merge (
    input  logic               clk,
    input  logic               en,
    input  oba_pkg::rank_t     rank,
    input  oba_pkg::lane_res_t lane_res [oba_pkg::NUM_AXES],
    output logic               not_adjacent,
    output logic [1:0]         nested_axes
);

    logic       not_adjacent_reg, not_adjacent_next;
    logic [1:0] nested_axes_reg, nested_axes_next;
    logic [1:0] count;

    always_comb
    begin
        not_adjacent_next = 1'b0;
        count             = 2'd0;
        for (int ax = 0; ax < oba_pkg::NUM_AXES; ax++)
        begin
            if (oba_pkg::rank_t'(ax) < rank)
            begin
                if (lane_res[ax].apart)
                begin
                    not_adjacent_next = 1'b1;
                end
                if (lane_res[ax].nest)
                begin
                    count = count + 2'd1;
                end
            end
        end
        nested_axes_next = not_adjacent_next ? 2'd0 : count;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            not_adjacent_reg <= not_adjacent_next;
            nested_axes_reg  <= nested_axes_next;
        end
    end

    assign not_adjacent = not_adjacent_reg;
    assign nested_axes  = nested_axes_reg;

endmodule
`default_nettype wire

>>> design/octree_block_adjacency.sv
`default_nettype none
// ----------------------------------------------------------------------------
// octree_block_adjacency
// Tests whether two octree blocks are face, edge or corner neighbors.
//
// A request on the input channel carries two blocks, each as a level and a
// packed root-index / tree-path coordinate per axis. It is taken at a clock
// edge with in_valid high and in_stall low. One result per request leaves on
// the output channel (not_adjacent, nested_axes) and is taken when out_valid
// is high and out_stall low. Results keep request order.
// A request passes the interval, flag, remainder and output stages;
// one request is taken per cycle while in_stall is low. The depth is set by
// the periodic remainder: one quotient bit per stage in all three axis lanes.
// Every stage holds its request only while the stages after it are full, so
// a stalled receiver fills the pipeline before in_stall rises.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// rank and the three periods; cfg_ready is always high. Write it only while
// no request is in flight.
// Reset empties the pipeline and sets rank to 3 and all periods to zero.
// ----------------------------------------------------------------------------
module octree_block_adjacency (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  oba_pkg::cfg_index_t cfg_index,
    input  oba_pkg::period_t    cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  oba_pkg::coord_t     a_x,
    input  oba_pkg::coord_t     a_y,
    input  oba_pkg::coord_t     a_z,
    input  oba_pkg::level_t     a_level,
    input  oba_pkg::coord_t     b_x,
    input  oba_pkg::coord_t     b_y,
    input  oba_pkg::coord_t     b_z,
    input  oba_pkg::level_t     b_level,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                not_adjacent,
    output logic [1:0]          nested_axes
);

    function automatic oba_pkg::lm_t clamp_level(input oba_pkg::level_t lv);
        if (lv > oba_pkg::level_t'(oba_pkg::TREE_BITS))
        begin
            return oba_pkg::lm_t'(oba_pkg::TREE_BITS);
        end
        return oba_pkg::lm_t'(lv);
    endfunction

    oba_pkg::rank_t   rank_reg;
    oba_pkg::period_t period_reg [oba_pkg::NUM_AXES];

    logic [oba_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    logic [oba_pkg::NUM_STAGES:0]   ready_vec;
    oba_pkg::stage_en_t             stage_en;

    oba_pkg::lm_t         la, lb;
    oba_pkg::level_info_t lvl;
    oba_pkg::lm_t         lm_reg;

    oba_pkg::coord_t    a_coord  [oba_pkg::NUM_AXES];
    oba_pkg::coord_t    b_coord  [oba_pkg::NUM_AXES];
    oba_pkg::lane_res_t lane_res [oba_pkg::NUM_AXES];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= oba_pkg::RANK_RESET;
            period_reg[0] <= '0;
            period_reg[1] <= '0;
            period_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                oba_pkg::REG_RANK:     rank_reg      <= cfg_data[oba_pkg::RANK_W-1:0];
                oba_pkg::REG_PERIOD_X: period_reg[0] <= cfg_data;
                oba_pkg::REG_PERIOD_Y: period_reg[1] <= cfg_data;
                oba_pkg::REG_PERIOD_Z: period_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow: a stage loads when it is empty or its contents move on.
    always_comb
    begin
        ready_vec[oba_pkg::NUM_STAGES] = !out_stall;
        for (int k = oba_pkg::NUM_STAGES - 1; k >= 0; k--)
        begin
            ready_vec[k] = !valid_reg[k] || ready_vec[k+1];
        end
        for (int k = 0; k < oba_pkg::NUM_STAGES; k++)
        begin
            if (k == 0)
            begin
                stage_en[k]   = ready_vec[k] && in_valid;
                valid_next[k] = ready_vec[k] ? in_valid : valid_reg[k];
            end
            else
            begin
                stage_en[k]   = ready_vec[k] && valid_reg[k-1];
                valid_next[k] = ready_vec[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready_vec[0];
    assign out_valid = valid_reg[oba_pkg::NUM_STAGES-1];

    // Both blocks are compared at the finer of the two levels.
    always_comb
    begin
        la     = clamp_level(a_level);
        lb     = clamp_level(b_level);
        lvl.lm = (la > lb) ? la : lb;
        lvl.da = lvl.lm - la;
        lvl.db = lvl.lm - lb;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            lm_reg <= lvl.lm;
        end
    end

    assign a_coord[0] = a_x;
    assign a_coord[1] = a_y;
    assign a_coord[2] = a_z;
    assign b_coord[0] = b_x;
    assign b_coord[1] = b_y;
    assign b_coord[2] = b_z;

    genvar ax;
    generate
        for (ax = 0; ax < oba_pkg::NUM_AXES; ax++)
        begin : g_lane
            oba_lane u_lane (
                .clk     (clk),
                .en      (stage_en),
                .lvl     (lvl),
                .lm_s0   (lm_reg),
                .a_coord (a_coord[ax]),
                .b_coord (b_coord[ax]),
                .period  (period_reg[ax]),
                .res     (lane_res[ax])
            );
        end
    endgenerate

    oba_merge u_merge (
        .clk          (clk),
        .en           (stage_en[oba_pkg::NUM_STAGES-1]),
        .rank         (rank_reg),
        .lane_res     (lane_res),
        .not_adjacent (not_adjacent),
        .nested_axes  (nested_axes)
    );

`ifndef NO_ASSERTIONS
    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !in_stall)
        else $error("input stalled with an empty first stage");

    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && !out_acc) |=>
        ($countones(valid_reg) == $past($countones(valid_reg))))
        else $error("request lost or duplicated inside the pipeline");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[oba_pkg::NUM_STAGES-2] && !(out_valid && out_stall)) |=> out_valid)
        else $error("finished request did not reach the output register");

    a_apart_no_nest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_adjacent) |-> (nested_axes == 2'd0))
        else $error("nested axes reported for a non-adjacent pair");
`endif

endmodule
`default_nettype wire
